// ===== design/cbb_pkg.sv =====
package cbb_pkg;

    localparam int FRONT_STAGES = 7;
    localparam int SQRT_STAGES  = 31;
    localparam int DIV_STAGES   = 31;
    // Front end, square root, numerator setup, divider, output register.
    localparam int UNIT_LAT     = FRONT_STAGES + SQRT_STAGES + 1 + DIV_STAGES + 1;

    localparam int NUM_CORNERS      = 8;
    localparam logic [2:0] LAST_CORNER = 3'd7;

    typedef struct packed {
        logic signed [31:0] centre_x;
        logic signed [31:0] centre_y;
        logic signed [31:0] centre_z;
        logic signed [31:0] axis_x;
        logic signed [31:0] axis_y;
        logic signed [31:0] axis_z;
        logic [30:0]        radius;
        logic [30:0]        height;
    } t_cyl_in;

    typedef struct packed {
        logic [2:0]         corner_index;
        logic signed [31:0] corner_x;
        logic signed [31:0] corner_y;
        logic signed [31:0] corner_z;
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_min_z;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_max_y;
        logic signed [31:0] box_max_z;
        logic               is_last;
    } t_corner_out;

    // Vector into the normalizer: three two's complement 64-bit components.
    typedef struct packed {
        logic             valid;
        logic [2:0][63:0] w;
    } t_unit_in;

    // Unit vector out of the normalizer: Q2.30 in 32-bit two's complement.
    typedef struct packed {
        logic             valid;
        logic [2:0][31:0] u;
    } t_unit_out;

endpackage

// ===== design/cbb_unit.sv =====
module cbb_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  cbb_pkg::t_unit_in  i_vec,
    output cbb_pkg::t_unit_out o_vec
);
    import cbb_pkg::*;

    typedef struct packed {
        logic             valid;
        logic [2:0]       neg;
        logic [2:0][63:0] m;
        logic [63:0]      mx;
    } t_fa;

    typedef struct packed {
        logic             valid;
        logic [2:0]       neg;
        logic [2:0][63:0] m;
        logic [3:0]       nz;
        logic [3:0][3:0]  cpos;
    } t_fb;

    typedef struct packed {
        logic             valid;
        logic [2:0]       neg;
        logic [2:0][63:0] m;
        logic [5:0]       p;
        logic             zero;
    } t_fc;

    typedef struct packed {
        logic             valid;
        logic [2:0]       neg;
        logic             zero;
        logic [2:0][29:0] mn;
        logic [2:0][59:0] sq;
        logic [61:0]      sum;
    } t_fd;

    typedef struct packed {
        logic             valid;
        logic [2:0]       neg;
        logic             zero;
        logic [2:0][29:0] mn;
        logic [61:0]      rem;
        logic [30:0]      res;
    } t_sq;

    typedef struct packed {
        logic             valid;
        logic [2:0]       neg;
        logic             zero;
        logic [30:0]      len;
        logic [2:0][61:0] rem;
        logic [2:0][30:0] q;
    } t_dv;

    t_fa       r_f1, n_f1, r_f2, n_f2;
    t_fb       r_f3, n_f3;
    t_fc       r_f4, n_f4;
    t_fd       r_f5, n_f5, r_f6, n_f6, r_f7, n_f7;
    t_sq       r_sq [SQRT_STAGES];
    t_sq       n_sq [SQRT_STAGES];
    t_dv       r_dp, n_dp;
    t_dv       r_dv [DIV_STAGES];
    t_dv       n_dv [DIV_STAGES];
    t_unit_out r_out, n_out;

    // Magnitudes and signs.
    always_comb begin
        n_f1       = '0;
        n_f1.valid = i_vec.valid;
        for (int i = 0; i < 3; i++) begin
            n_f1.neg[i] = i_vec.w[i][63];
            n_f1.m[i]   = i_vec.w[i][63] ? (64'd0 - i_vec.w[i]) : i_vec.w[i];
        end
    end

    // Largest magnitude.
    always_comb begin
        n_f2    = r_f1;
        n_f2.mx = (r_f1.m[0] > r_f1.m[1]) ? r_f1.m[0] : r_f1.m[1];
        if (r_f1.m[2] > n_f2.mx) begin
            n_f2.mx = r_f1.m[2];
        end
    end

    // Leading one inside each 16-bit slice of the largest magnitude.
    always_comb begin
        n_f3       = '0;
        n_f3.valid = r_f2.valid;
        n_f3.neg   = r_f2.neg;
        n_f3.m     = r_f2.m;
        for (int c = 0; c < 4; c++) begin
            n_f3.nz[c] = |r_f2.mx[16*c +: 16];
            for (int j = 0; j < 16; j++) begin
                if (r_f2.mx[16*c + j]) begin
                    n_f3.cpos[c] = 4'(j);
                end
            end
        end
    end

    always_comb begin
        n_f4       = '0;
        n_f4.valid = r_f3.valid;
        n_f4.neg   = r_f3.neg;
        n_f4.m     = r_f3.m;
        n_f4.zero  = ~|r_f3.nz;
        for (int c = 0; c < 4; c++) begin
            if (r_f3.nz[c]) begin
                n_f4.p = {2'(c), r_f3.cpos[c]};
            end
        end
    end

    // Common shift that puts the largest magnitude in [2^29, 2^30).
    always_comb begin
        logic [63:0] sh;
        n_f5       = '0;
        n_f5.valid = r_f4.valid;
        n_f5.neg   = r_f4.neg;
        n_f5.zero  = r_f4.zero;
        for (int i = 0; i < 3; i++) begin
            if (r_f4.p >= 6'd29) begin
                sh = r_f4.m[i] >> (r_f4.p - 6'd29);
            end else begin
                sh = r_f4.m[i] << (6'd29 - r_f4.p);
            end
            n_f5.mn[i] = sh[29:0];
        end
    end

    always_comb begin
        n_f6 = r_f5;
        for (int i = 0; i < 3; i++) begin
            n_f6.sq[i] = 60'(r_f5.mn[i]) * 60'(r_f5.mn[i]);
        end
    end

    always_comb begin
        n_f7     = r_f6;
        n_f7.sum = 62'(r_f6.sq[0]) + 62'(r_f6.sq[1]) + 62'(r_f6.sq[2]);
    end

    // Square root, one result bit per stage, most significant first.
    always_comb begin
        t_sq         s;
        logic [63:0] trial;
        for (int k = 0; k < SQRT_STAGES; k++) begin
            if (k == 0) begin
                s       = '0;
                s.valid = r_f7.valid;
                s.neg   = r_f7.neg;
                s.zero  = r_f7.zero;
                s.mn    = r_f7.mn;
                s.rem   = r_f7.sum;
            end else begin
                s = r_sq[k-1];
            end
            trial = ({33'd0, s.res} << (SQRT_STAGES - k))
                  + (64'd1 << (2 * (SQRT_STAGES - 1 - k)));
            if ({2'b00, s.rem} >= trial) begin
                s.rem                       = s.rem - trial[61:0];
                s.res[SQRT_STAGES - 1 - k] = 1'b1;
            end
            n_sq[k] = s;
        end
    end

    // Numerators carry half the length so that the quotient rounds.
    always_comb begin
        n_dp       = '0;
        n_dp.valid = r_sq[SQRT_STAGES-1].valid;
        n_dp.neg   = r_sq[SQRT_STAGES-1].neg;
        n_dp.zero  = r_sq[SQRT_STAGES-1].zero;
        n_dp.len   = r_sq[SQRT_STAGES-1].res;
        for (int i = 0; i < 3; i++) begin
            n_dp.rem[i] = {2'b00, r_sq[SQRT_STAGES-1].mn[i], 30'd0}
                        + 62'(r_sq[SQRT_STAGES-1].res >> 1);
        end
    end

    // Restoring divide, one quotient bit per stage in each lane.
    always_comb begin
        t_dv         s;
        logic [63:0] d;
        for (int k = 0; k < DIV_STAGES; k++) begin
            s = (k == 0) ? r_dp : r_dv[k-1];
            d = {33'd0, s.len} << (DIV_STAGES - 1 - k);
            for (int i = 0; i < 3; i++) begin
                if ({2'b00, s.rem[i]} >= d) begin
                    s.rem[i]                   = s.rem[i] - d[61:0];
                    s.q[i][DIV_STAGES - 1 - k] = 1'b1;
                end
            end
            n_dv[k] = s;
        end
    end

    always_comb begin
        n_out       = '0;
        n_out.valid = r_dv[DIV_STAGES-1].valid;
        for (int i = 0; i < 3; i++) begin
            if (r_dv[DIV_STAGES-1].zero) begin
                n_out.u[i] = 32'd0;
            end else if (r_dv[DIV_STAGES-1].neg[i]) begin
                n_out.u[i] = 32'd0 - {1'b0, r_dv[DIV_STAGES-1].q[i]};
            end else begin
                n_out.u[i] = {1'b0, r_dv[DIV_STAGES-1].q[i]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1.valid  <= 1'b0;
            r_f2.valid  <= 1'b0;
            r_f3.valid  <= 1'b0;
            r_f4.valid  <= 1'b0;
            r_f5.valid  <= 1'b0;
            r_f6.valid  <= 1'b0;
            r_f7.valid  <= 1'b0;
            r_dp.valid  <= 1'b0;
            r_out.valid <= 1'b0;
            for (int k = 0; k < SQRT_STAGES; k++) begin
                r_sq[k].valid <= 1'b0;
            end
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_dv[k].valid <= 1'b0;
            end
        end else if (i_en) begin
            r_f1  <= n_f1;
            r_f2  <= n_f2;
            r_f3  <= n_f3;
            r_f4  <= n_f4;
            r_f5  <= n_f5;
            r_f6  <= n_f6;
            r_f7  <= n_f7;
            r_dp  <= n_dp;
            r_out <= n_out;
            for (int k = 0; k < SQRT_STAGES; k++) begin
                r_sq[k] <= n_sq[k];
            end
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_dv[k] <= n_dv[k];
            end
        end
    end

    assign o_vec = r_out;

endmodule

// ===== design/cylinder_bounding_box_top.sv =====
// Cylinder bounding box: each accepted beat describes one cylinder and yields eight
// result beats, the corners of its oriented box (0-3 at the plus-axis end, 4-7 at the
// minus-axis end); the eighth beat sets is_last and carries the axis-aligned box.
// Results come out one beat per cycle while i_stall is low, so the single result
// channel limits the sustained rate to one cylinder per eight beats. The datapath
// is a stalling pipeline of 2 * 71 + 10 = 152 stages, nearly all in the two vector
// normalizers (square root and divide, one bit per stage). Further cylinders are
// taken while earlier corners drain.
module cylinder_bounding_box_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  cbb_pkg::t_cyl_in     i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output cbb_pkg::t_corner_out o_data
);
    import cbb_pkg::*;

    typedef struct packed {
        logic [2:0][31:0] c;
        logic [2:0][31:0] a;
        logic [30:0]      r;
        logic [29:0]      half;
    } t_d1;

    typedef struct packed {
        logic             valid;
        logic [2:0][63:0] pl;
        logic [2:0][63:0] pr;
        logic [2:0][63:0] pe;
        logic [2:0]       an;
        logic [2:0][31:0] c;
        logic [2:0][31:0] u;
        logic [30:0]      r;
    } t_p2;

    typedef struct packed {
        logic [2:0][31:0] c;
        logic [2:0][31:0] u;
        logic [2:0][47:0] e;
        logic [30:0]      r;
    } t_d2;

    typedef struct packed {
        logic                  valid;
        logic [2:0][63:0]      pu;
        logic [2:0][63:0]      pv;
        logic [2:0]            un;
        logic [2:0]            vn;
        logic [1:0][2:0][31:0] ends;
    } t_p4;

    typedef struct packed {
        logic                  valid;
        logic [2:0][47:0]      su;
        logic [2:0][47:0]      sv;
        logic [1:0][2:0][31:0] ends;
    } t_p5;

    typedef struct packed {
        logic                  valid;
        logic [7:0][2:0][31:0] corner;
        logic [3:0][2:0][31:0] mn;
        logic [3:0][2:0][31:0] mx;
    } t_pc;

    function automatic logic [31:0] sat32(input logic signed [47:0] x);
        if (x > 48'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (x < -48'sd2147483648) begin
            return 32'h8000_0000;
        end
        return x[31:0];
    endfunction

    function automatic logic signed [63:0] smul(input logic signed [31:0] x,
                                               input logic signed [31:0] y);
        logic signed [63:0] xe;
        logic signed [63:0] ye;
        xe = 64'(x);
        ye = 64'(y);
        return xe * ye;
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] x);
        return x[31] ? (32'd0 - x) : x;
    endfunction

    logic      w_adv;
    logic      w_load_ok;
    t_unit_in  r_u1in, n_u1in, r_u2in, n_u2in;
    t_unit_out w_u1out, w_u2out;
    t_d1       r_p1, n_p1;
    t_d1       r_d1 [UNIT_LAT];
    t_p2       r_p2, n_p2;
    t_d2       r_p3, n_p3;
    t_d2       r_d2 [UNIT_LAT];
    t_p4       r_p4, n_p4;
    t_p5       r_p5, n_p5;
    t_pc       r_p6, n_p6, r_p7, n_p7, r_p8, n_p8, r_p9, n_p9;
    t_pc       r_ser;
    logic      r_busy;
    logic [2:0] r_idx;

    // Input beat: pick the first perpendicular, axis x (0,1,0) or axis x (1,0,0).
    always_comb begin
        logic [63:0] ax, ay, az;
        ax = 64'($signed(i_data.axis_x));
        ay = 64'($signed(i_data.axis_y));
        az = 64'($signed(i_data.axis_z));
        n_u1in       = '0;
        n_u1in.valid = i_valid;
        if ((|i_data.axis_x) || (|i_data.axis_z)) begin
            n_u1in.w[0] = 64'd0 - az;
            n_u1in.w[2] = ax;
        end else begin
            n_u1in.w[1] = az;
            n_u1in.w[2] = 64'd0 - ay;
        end
        n_p1.c    = {i_data.centre_z, i_data.centre_y, i_data.centre_x};
        n_p1.a    = {i_data.axis_z, i_data.axis_y, i_data.axis_x};
        n_p1.r    = i_data.radius;
        n_p1.half = i_data.height[30:1];
    end

    cbb_unit u_unit1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vec   (r_u1in),
        .o_vec   (w_u1out)
    );

    // Products for the second cross product u x axis and for the end offsets.
    always_comb begin
        t_d1 d;
        d          = r_d1[UNIT_LAT-1];
        n_p2.valid = w_u1out.valid;
        n_p2.u     = w_u1out.u;
        n_p2.c     = d.c;
        n_p2.r     = d.r;
        n_p2.pl[0] = smul(w_u1out.u[1], d.a[2]);
        n_p2.pr[0] = smul(w_u1out.u[2], d.a[1]);
        n_p2.pl[1] = smul(w_u1out.u[2], d.a[0]);
        n_p2.pr[1] = smul(w_u1out.u[0], d.a[2]);
        n_p2.pl[2] = smul(w_u1out.u[0], d.a[1]);
        n_p2.pr[2] = smul(w_u1out.u[1], d.a[0]);
        for (int i = 0; i < 3; i++) begin
            n_p2.an[i] = d.a[i][31];
            n_p2.pe[i] = 64'(mag32(d.a[i])) * 64'(d.half);
        end
    end

    always_comb begin
        logic [63:0] m;
        n_u2in       = '0;
        n_u2in.valid = r_p2.valid;
        n_p3.c       = r_p2.c;
        n_p3.u       = r_p2.u;
        n_p3.r       = r_p2.r;
        for (int i = 0; i < 3; i++) begin
            n_u2in.w[i] = r_p2.pl[i] - r_p2.pr[i];
            m           = (r_p2.pe[i] + 64'd32768) >> 16;
            n_p3.e[i]   = r_p2.an[i] ? (48'd0 - m[47:0]) : m[47:0];
        end
    end

    cbb_unit u_unit2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vec   (r_u2in),
        .o_vec   (w_u2out)
    );

    // Radius products and the two saturated end centres.
    always_comb begin
        t_d2 d;
        d          = r_d2[UNIT_LAT-1];
        n_p4.valid = w_u2out.valid;
        for (int i = 0; i < 3; i++) begin
            n_p4.un[i]      = d.u[i][31];
            n_p4.vn[i]      = w_u2out.u[i][31];
            n_p4.pu[i]      = 64'(mag32(d.u[i])) * 64'(d.r);
            n_p4.pv[i]      = 64'(mag32(w_u2out.u[i])) * 64'(d.r);
            n_p4.ends[0][i] = sat32(48'($signed(d.c[i])) + $signed(d.e[i]));
            n_p4.ends[1][i] = sat32(48'($signed(d.c[i])) - $signed(d.e[i]));
        end
    end

    always_comb begin
        logic [63:0] mu, mv;
        n_p5.valid = r_p4.valid;
        n_p5.ends  = r_p4.ends;
        for (int i = 0; i < 3; i++) begin
            mu         = (r_p4.pu[i] + (64'd1 << 29)) >> 30;
            mv         = (r_p4.pv[i] + (64'd1 << 29)) >> 30;
            n_p5.su[i] = r_p4.un[i] ? (48'd0 - mu[47:0]) : mu[47:0];
            n_p5.sv[i] = r_p4.vn[i] ? (48'd0 - mv[47:0]) : mv[47:0];
        end
    end

    always_comb begin
        logic signed [47:0] b, su, sv;
        n_p6       = '0;
        n_p6.valid = r_p5.valid;
        for (int k = 0; k < 2; k++) begin
            for (int i = 0; i < 3; i++) begin
                b  = 48'($signed(r_p5.ends[k][i]));
                su = $signed(r_p5.su[i]);
                sv = $signed(r_p5.sv[i]);
                n_p6.corner[4*k + 0][i] = sat32(b + su + sv);
                n_p6.corner[4*k + 1][i] = sat32(b + sv - su);
                n_p6.corner[4*k + 2][i] = sat32(b - su - sv);
                n_p6.corner[4*k + 3][i] = sat32(b + su - sv);
            end
        end
    end

    // Registered min/max tree over the eight corners, one level per stage.
    always_comb begin
        n_p7        = '0;
        n_p7.valid  = r_p6.valid;
        n_p7.corner = r_p6.corner;
        for (int j = 0; j < 4; j++) begin
            for (int i = 0; i < 3; i++) begin
                if ($signed(r_p6.corner[2*j][i]) < $signed(r_p6.corner[2*j+1][i])) begin
                    n_p7.mn[j][i] = r_p6.corner[2*j][i];
                    n_p7.mx[j][i] = r_p6.corner[2*j+1][i];
                end else begin
                    n_p7.mn[j][i] = r_p6.corner[2*j+1][i];
                    n_p7.mx[j][i] = r_p6.corner[2*j][i];
                end
            end
        end
    end

    always_comb begin
        n_p8        = '0;
        n_p8.valid  = r_p7.valid;
        n_p8.corner = r_p7.corner;
        for (int j = 0; j < 2; j++) begin
            for (int i = 0; i < 3; i++) begin
                n_p8.mn[j][i] = ($signed(r_p7.mn[2*j][i]) < $signed(r_p7.mn[2*j+1][i]))
                              ? r_p7.mn[2*j][i] : r_p7.mn[2*j+1][i];
                n_p8.mx[j][i] = ($signed(r_p7.mx[2*j][i]) > $signed(r_p7.mx[2*j+1][i]))
                              ? r_p7.mx[2*j][i] : r_p7.mx[2*j+1][i];
            end
        end
    end

    always_comb begin
        n_p9        = '0;
        n_p9.valid  = r_p8.valid;
        n_p9.corner = r_p8.corner;
        for (int i = 0; i < 3; i++) begin
            n_p9.mn[0][i] = ($signed(r_p8.mn[0][i]) < $signed(r_p8.mn[1][i]))
                          ? r_p8.mn[0][i] : r_p8.mn[1][i];
            n_p9.mx[0][i] = ($signed(r_p8.mx[0][i]) > $signed(r_p8.mx[1][i]))
                          ? r_p8.mx[0][i] : r_p8.mx[1][i];
        end
    end

    // The whole pipeline moves together; it holds only when a finished cylinder
    // waits and the output register still has corners of the previous one to send.
    assign w_load_ok = !r_busy || (!i_stall && (r_idx == LAST_CORNER));
    assign w_adv     = !r_p9.valid || w_load_ok;
    assign o_stall   = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u1in.valid <= 1'b0;
            r_u2in.valid <= 1'b0;
            r_p2.valid   <= 1'b0;
            r_p4.valid   <= 1'b0;
            r_p5.valid   <= 1'b0;
            r_p6.valid   <= 1'b0;
            r_p7.valid   <= 1'b0;
            r_p8.valid   <= 1'b0;
            r_p9.valid   <= 1'b0;
        end else if (w_adv) begin
            r_u1in <= n_u1in;
            r_u2in <= n_u2in;
            r_p2   <= n_p2;
            r_p4   <= n_p4;
            r_p5   <= n_p5;
            r_p6   <= n_p6;
            r_p7   <= n_p7;
            r_p8   <= n_p8;
            r_p9   <= n_p9;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p1    <= n_p1;
            r_p3    <= n_p3;
            r_d1[0] <= r_p1;
            r_d2[0] <= r_p3;
            for (int k = 1; k < UNIT_LAT; k++) begin
                r_d1[k] <= r_d1[k-1];
                r_d2[k] <= r_d2[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else if (r_p9.valid && w_load_ok) begin
            r_busy <= 1'b1;
            r_idx  <= 3'd0;
        end else if (r_busy && !i_stall) begin
            if (r_idx == LAST_CORNER) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p9.valid && w_load_ok) begin
            r_ser <= r_p9;
        end
    end

    always_comb begin
        logic last;
        last                = (r_idx == LAST_CORNER);
        o_data              = '0;
        o_data.corner_index = r_idx;
        o_data.corner_x     = r_ser.corner[r_idx][0];
        o_data.corner_y     = r_ser.corner[r_idx][1];
        o_data.corner_z     = r_ser.corner[r_idx][2];
        o_data.is_last      = last;
        if (last) begin
            o_data.box_min_x = r_ser.mn[0][0];
            o_data.box_min_y = r_ser.mn[0][1];
            o_data.box_min_z = r_ser.mn[0][2];
            o_data.box_max_x = r_ser.mx[0][0];
            o_data.box_max_y = r_ser.mx[0][1];
            o_data.box_max_z = r_ser.mx[0][2];
        end
    end

    assign o_valid = r_busy;

    a_corner_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_stall && r_idx != LAST_CORNER)
        |=> (r_busy && r_idx == $past(r_idx) + 3'd1))
        else $error("corner index did not advance after an accepted beat");

    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p9.valid && w_load_ok) |=> (r_busy && r_idx == 3'd0))
        else $error("finished cylinder not loaded into the output register");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> (r_p9.valid && $stable(r_p9)))
        else $error("pipeline tail changed while held");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_busy && r_p9.valid))
        else $error("input stalled with no pending output");

endmodule

// ===== dv/cylinder_bounding_box_top_test.sv =====
`timescale 1ns / 1ps

module cylinder_bounding_box_top_test;
    import cbb_pkg::*;

    localparam int LATENCY    = 160;
    localparam int IDLE_LIMIT = 4000;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_cyl_in     i_data;
    logic        o_valid;
    logic        i_stall;
    t_corner_out o_data;

    cylinder_bounding_box_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    t_corner_out corner_queue[$];
    int          error_count;
    int          cylinders_sent;
    int          corners_checked;
    int          idle_cycles;
    bit          hold_output;
    bit          backpressure_busy;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic longint clamp32(longint x);
        if (x > S32_MAX) begin
            return S32_MAX;
        end
        if (x < S32_MIN) begin
            return S32_MIN;
        end
        return x;
    endfunction

    // Rounds |a|*b / 2^sh half away from zero and puts back the sign of a.
    function automatic longint scale_round(longint a, longint unsigned b, int sh);
        longint unsigned mag;
        longint unsigned p;
        mag = (a < 0) ? longint'(-a) : longint'(a);
        p = (mag * b + (64'd1 << (sh - 1))) >> sh;
        return (a < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) begin
            bitv = bitv >> 2;
        end
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Q2.30 unit vector; the zero vector stays zero.
    task automatic normalize(input longint w[3], output longint o[3]);
        longint unsigned m[3];
        longint unsigned mx;
        longint unsigned sq;
        longint unsigned len;
        longint unsigned q;
        mx = 0;
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = (w[i] < 0) ? longint'(-w[i]) : longint'(w[i]);
            if (m[i] > mx) begin
                mx = m[i];
            end
        end
        if (mx == 0) begin
            for (int i = 0; i < 3; i++) begin
                o[i] = 0;
            end
            return;
        end
        while (mx >= (64'd1 << 30)) begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) begin
                m[i] = m[i] >> 1;
            end
        end
        while (mx < (64'd1 << 29)) begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) begin
                m[i] = m[i] << 1;
            end
        end
        for (int i = 0; i < 3; i++) begin
            sq = sq + m[i] * m[i];
        end
        len = int_sqrt(sq);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << 30) + (len >> 1)) / len;
            o[i] = (w[i] < 0) ? -longint'(q) : longint'(q);
        end
    endtask

    task automatic predict_corners(input t_cyl_in cyl);
        longint      c[3], a[3], ends[2][3], w[3], u[3], v[3], su[3], sv[3];
        longint      pt[8][3], lo[3], hi[3];
        longint      off;
        longint unsigned rad;
        longint unsigned half;
        t_corner_out res;
        rad  = cyl.radius;
        half = cyl.height >> 1;
        c[0] = cyl.centre_x;
        c[1] = cyl.centre_y;
        c[2] = cyl.centre_z;
        a[0] = cyl.axis_x;
        a[1] = cyl.axis_y;
        a[2] = cyl.axis_z;
        for (int i = 0; i < 3; i++) begin
            off = scale_round(a[i], half, 16);
            ends[0][i] = clamp32(c[i] + off);
            ends[1][i] = clamp32(c[i] - off);
        end
        if (a[0] != 0 || a[2] != 0) begin
            w[0] = -a[2];
            w[1] = 0;
            w[2] = a[0];
        end else begin
            w[0] = 0;
            w[1] = a[2];
            w[2] = -a[1];
        end
        normalize(w, u);
        w[0] = u[1] * a[2] - u[2] * a[1];
        w[1] = u[2] * a[0] - u[0] * a[2];
        w[2] = u[0] * a[1] - u[1] * a[0];
        normalize(w, v);
        for (int i = 0; i < 3; i++) begin
            su[i] = scale_round(u[i], rad, 30);
            sv[i] = scale_round(v[i], rad, 30);
        end
        for (int k = 0; k < 2; k++) begin
            for (int i = 0; i < 3; i++) begin
                pt[k*4 + 0][i] = clamp32(ends[k][i] + su[i] + sv[i]);
                pt[k*4 + 1][i] = clamp32(ends[k][i] + sv[i] - su[i]);
                pt[k*4 + 2][i] = clamp32(ends[k][i] - su[i] - sv[i]);
                pt[k*4 + 3][i] = clamp32(ends[k][i] + su[i] - sv[i]);
            end
        end
        for (int i = 0; i < 3; i++) begin
            lo[i] = pt[0][i];
            hi[i] = pt[0][i];
            for (int k = 1; k < NUM_CORNERS; k++) begin
                if (pt[k][i] < lo[i]) begin
                    lo[i] = pt[k][i];
                end
                if (pt[k][i] > hi[i]) begin
                    hi[i] = pt[k][i];
                end
            end
        end
        for (int k = 0; k < NUM_CORNERS; k++) begin
            res = '0;
            res.corner_index = k[2:0];
            res.corner_x = pt[k][0][31:0];
            res.corner_y = pt[k][1][31:0];
            res.corner_z = pt[k][2][31:0];
            if (res.corner_index == LAST_CORNER) begin
                res.box_min_x = lo[0][31:0];
                res.box_min_y = lo[1][31:0];
                res.box_min_z = lo[2][31:0];
                res.box_max_x = hi[0][31:0];
                res.box_max_y = hi[1][31:0];
                res.box_max_z = hi[2][31:0];
                res.is_last = 1'b1;
            end
            corner_queue.push_back(res);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
    endtask

    // Sends one cylinder after a random gap; the beat is predicted on acceptance.
    task automatic send_cylinder(input t_cyl_in cyl);
        int gap;
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) begin
            gap = 0;
        end
        repeat (gap) @(negedge i_clk);
        i_valid = 1'b1;
        i_data  = cyl;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        predict_corners(cyl);
        cylinders_sent++;
        @(negedge i_clk);
        i_valid = 1'b0;
        i_data  = '0;
    endtask

    function automatic logic [31:0] rand_word();
        return $urandom;
    endfunction

    function automatic t_cyl_in random_cylinder();
        t_cyl_in cyl;
        logic signed [31:0] unit_val;
        int pick;
        cyl.centre_x = ($urandom_range(0, 4) == 0) ? $signed(rand_word())
                                                   : $signed(rand_word()) >>> 8;
        cyl.centre_y = ($urandom_range(0, 4) == 0) ? $signed(rand_word())
                                                   : $signed(rand_word()) >>> 8;
        cyl.centre_z = ($urandom_range(0, 4) == 0) ? $signed(rand_word())
                                                   : $signed(rand_word()) >>> 8;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            // Roughly unit-length axis with random direction.
            cyl.axis_x = $signed(rand_word()) >>> 15;
            cyl.axis_y = $signed(rand_word()) >>> 15;
            cyl.axis_z = $signed(rand_word()) >>> 15;
        end else if (pick == 6) begin
            unit_val = ($urandom_range(0, 1) != 0) ? 32'sh10000 : -32'sh10000;
            cyl.axis_x = 0;
            cyl.axis_y = unit_val;
            cyl.axis_z = 0;
        end else begin
            cyl.axis_x = rand_word();
            cyl.axis_y = rand_word();
            cyl.axis_z = rand_word();
        end
        cyl.radius = 31'(($urandom_range(0, 3) == 0) ? rand_word() : rand_word() >> 10);
        cyl.height = 31'(($urandom_range(0, 3) == 0) ? rand_word() : rand_word() >> 10);
        return cyl;
    endfunction

    function automatic t_cyl_in make_cylinder(input logic [31:0] cx, input logic [31:0] cy,
                                              input logic [31:0] cz, input logic [31:0] ax,
                                              input logic [31:0] ay, input logic [31:0] az,
                                              input logic [30:0] r, input logic [30:0] h);
        t_cyl_in cyl;
        cyl.centre_x = cx;
        cyl.centre_y = cy;
        cyl.centre_z = cz;
        cyl.axis_x = ax;
        cyl.axis_y = ay;
        cyl.axis_z = az;
        cyl.radius = r;
        cyl.height = h;
        return cyl;
    endfunction

    task automatic test_directed();
        send_cylinder(make_cylinder(0, 0, 0, 0, 32'h10000, 0, 31'h10000, 31'h20000));
        send_cylinder(make_cylinder(0, 0, 0, 0, 32'hFFFF0000, 0, 31'h10000, 31'h20000));
        send_cylinder(make_cylinder(32'h10000, 32'h20000, 32'h30000, 0, 0, 0,
                                    31'h7FFFFFFF, 31'h7FFFFFFF));
        send_cylinder(make_cylinder(0, 0, 0, 32'h10000, 0, 0, 31'h8000, 31'h40000));
        send_cylinder(make_cylinder(0, 0, 0, 0, 0, 32'h10000, 31'h8000, 31'h40000));
        send_cylinder(make_cylinder(0, 0, 0, 0, 0, 0, 0, 0));
        send_cylinder(make_cylinder(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                    32'h10000, 32'h10000, 32'h10000,
                                    31'h7FFFFFFF, 31'h7FFFFFFF));
        send_cylinder(make_cylinder(32'h80000000, 32'h80000000, 32'h80000000,
                                    32'h10000, 32'h10000, 32'h10000,
                                    31'h7FFFFFFF, 31'h7FFFFFFF));
        send_cylinder(make_cylinder(0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                    31'h7FFFFFFF, 31'h7FFFFFFF));
        send_cylinder(make_cylinder(0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000,
                                    31'h7FFFFFFF, 31'h7FFFFFFF));
        send_cylinder(make_cylinder(0, 0, 0, 0, 32'h80000000, 0, 31'h7FFFFFFF, 31'h1));
        send_cylinder(make_cylinder(0, 0, 0, 0, 32'h7FFFFFFF, 0, 31'h1, 31'h3));
        send_cylinder(make_cylinder(32'h12345678, 32'hEDCBA987, 32'h0, 32'h1, 32'hFFFFFFFF,
                                    32'h1, 31'h5555, 31'h2AAAA));
        send_cylinder(make_cylinder(32'hFFFFFFFF, 0, 1, 32'hB505, 0, 32'h4AFB,
                                    31'h30000, 31'h50001));
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++) begin
            send_cylinder(random_cylinder());
        end
    endtask

    // The sink is held off long enough for the pipeline to fill while cylinders keep coming.
    task automatic test_backpressure();
        fork
            begin
                backpressure_busy = 1'b1;
                hold_output = 1'b1;
                repeat (600) @(posedge i_clk);
                hold_output = 1'b0;
                backpressure_busy = 1'b0;
            end
            begin
                for (int n = 0; n < 40; n++) begin
                    send_cylinder(random_cylinder());
                end
            end
        join
    endtask

    // Sink: random stall per beat, checks against the oldest expected corner.
    initial begin
        int wait_cycles;
        t_corner_out want;
        t_corner_out got;
        i_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
            if ($urandom_range(0, 1) != 0) begin
                wait_cycles = 0;
            end
            @(negedge i_clk);
            i_stall = 1'b1;
            repeat (wait_cycles) @(negedge i_clk);
            while (hold_output) begin
                @(negedge i_clk);
            end
            i_stall = 1'b0;
            @(posedge i_clk);
            while (!o_valid) begin
                @(posedge i_clk);
            end
            got = o_data;
            if (corner_queue.size() == 0) begin
                report_mismatch("unexpected corner beat", got.corner_x, 32'h0);
            end else begin
                want = corner_queue.pop_front();
                corners_checked++;
                if (got.corner_index != want.corner_index)
                    report_mismatch("corner_index", got.corner_index, want.corner_index);
                if (got.corner_x != want.corner_x)
                    report_mismatch("corner_x", got.corner_x, want.corner_x);
                if (got.corner_y != want.corner_y)
                    report_mismatch("corner_y", got.corner_y, want.corner_y);
                if (got.corner_z != want.corner_z)
                    report_mismatch("corner_z", got.corner_z, want.corner_z);
                if (got.box_min_x != want.box_min_x)
                    report_mismatch("box_min_x", got.box_min_x, want.box_min_x);
                if (got.box_min_y != want.box_min_y)
                    report_mismatch("box_min_y", got.box_min_y, want.box_min_y);
                if (got.box_min_z != want.box_min_z)
                    report_mismatch("box_min_z", got.box_min_z, want.box_min_z);
                if (got.box_max_x != want.box_max_x)
                    report_mismatch("box_max_x", got.box_max_x, want.box_max_x);
                if (got.box_max_y != want.box_max_y)
                    report_mismatch("box_max_y", got.box_max_y, want.box_max_y);
                if (got.box_max_z != want.box_max_z)
                    report_mismatch("box_max_z", got.box_max_z, want.box_max_z);
                if (got.is_last != want.is_last)
                    report_mismatch("is_last", got.is_last, want.is_last);
            end
        end
    end

    // Watchdog: cycles without any accepted beat on either side; a long hold is expected.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || backpressure_busy) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("ERROR: no progress for %0d cycles", IDLE_LIMIT);
                $display("cylinder_bounding_box_top_test NOT OK");
                $finish;
            end
        end
    end

    initial begin
        error_count = 0;
        cylinders_sent = 0;
        corners_checked = 0;
        hold_output = 1'b0;
        backpressure_busy = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random(180);
        test_backpressure();
        test_random(200);
        while (corner_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY) @(posedge i_clk);
        $display("Sent %0d cylinders, checked %0d corner beats", cylinders_sent,
                 corners_checked);
        $display("Covered axis extremes, zero and y-parallel axes, saturation and long stalls.");
        if (error_count == 0 && corner_queue.size() == 0) begin
            $display("cylinder_bounding_box_top_test OK");
        end else begin
            $display("cylinder_bounding_box_top_test NOT OK");
        end
        $finish;
    end

endmodule
